>>> design/csvrp_pkg.sv
// shared types and constants for the csv record parser
`default_nettype none

package csvrp_pkg;

    localparam logic [7:0] QUOTE_BYTE      = 8'd34;
    localparam logic [7:0] NEWLINE_BYTE    = 8'd10;
    localparam logic [7:0] DELIMITER_RESET = 8'd44;

    typedef enum logic [1:0] {
        KIND_CHAR       = 2'd0,
        KIND_FIELD_END  = 2'd1,
        KIND_RECORD_END = 2'd2,
        KIND_ERROR      = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MODE_OUTSIDE = 2'd0,
        MODE_INSIDE  = 2'd1,
        MODE_PENDING = 2'd2
    } mode_t;

    typedef struct packed {
        logic       end_of_stream;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        kind_t      out_kind;
        logic [7:0] out_char;
    } result_t;

endpackage

`default_nettype wire

>>> design/csv_record_parser.sv
// top level of the streaming csv record parser
//
// Takes one byte transaction per cycle while not stalled and returns at most one event per
// byte: a field character, a field end, a record end or an unclosed-quote error. A byte is
// latched in the input register, decoded against the quote mode and record flag when it
// leaves that register, and its event is registered in the output register, so an event is
// offered on the master side once its byte has passed both registers. The quote-mode update
// is combinational into its register, which sets the sustained rate at one byte per cycle
// while the master side keeps up; a skid entry behind the output register takes the event
// in flight when the master side stalls, and the input stalls while that entry is occupied.
// The delimiter is written through the cfg channel, which is always ready; write it only
// while no byte is in flight.
`default_nettype none

module csv_record_parser
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data,      // delimiter
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,       // data_byte
    input  wire logic       s_tuser,       // end_of_stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,       // out_char
    output logic [1:0]      m_tuser        // out_kind
);

    csvrp_pkg::item_t   s_item;
    csvrp_pkg::item_t   item;
    csvrp_pkg::result_t result;
    csvrp_pkg::result_t m_result;
    logic               item_valid;
    logic               has_result;
    logic               up_ready;

    assign cfg_ready            = 1'b1;
    assign s_item.data_byte     = s_tdata;
    assign s_item.end_of_stream = s_tuser;
    assign m_tdata              = m_result.out_char;
    assign m_tuser              = m_result.out_kind;

    csvrp_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .down_ready (up_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    csvrp_step u_step
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .has_result (has_result),
        .result     (result)
    );

    csvrp_out_skid u_out_skid
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (item_valid && has_result),
        .push_result (result),
        .up_ready    (up_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_result    (m_result)
    );

endmodule

`default_nettype wire

>>> design/csvrp_in_stage.sv
// input register stage holding one accepted byte transaction
`default_nettype none

module csvrp_in_stage
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire csvrp_pkg::item_t s_item,
    input  wire logic            down_ready,
    output logic                 item_valid,
    output csvrp_pkg::item_t     item
);

    logic             valid_reg;
    logic             valid_next;
    csvrp_pkg::item_t item_reg;
    logic             take;

    assign s_tready   = !valid_reg || down_ready;
    assign take       = s_tvalid && s_tready;
    assign item_valid = valid_reg && down_ready;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (item_valid)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

>>> design/csvrp_step.sv
// tokenizer state, delimiter register and per-byte event logic
`default_nettype none

module csvrp_step
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    input  wire logic [7:0]       cfg_data,
    input  wire logic             item_valid,
    input  wire csvrp_pkg::item_t item,
    output logic                  has_result,
    output csvrp_pkg::result_t    result
);

    logic [7:0]       delimiter_reg;
    csvrp_pkg::mode_t quote_mode_reg;
    csvrp_pkg::mode_t quote_mode_next;
    logic             record_started_reg;
    logic             record_started_next;
    logic             is_quote;
    logic             is_newline;
    logic             is_delim;

    assign is_quote   = item.data_byte == csvrp_pkg::QUOTE_BYTE;
    assign is_newline = item.data_byte == csvrp_pkg::NEWLINE_BYTE;
    assign is_delim   = item.data_byte == delimiter_reg;

    // next state
    always_comb
    begin
        quote_mode_next     = quote_mode_reg;
        record_started_next = record_started_reg;
        if (item.end_of_stream)
        begin
            if (record_started_reg)
            begin
                quote_mode_next     = csvrp_pkg::MODE_OUTSIDE;
                record_started_next = 1'b0;
            end
        end
        else
        begin
            record_started_next = 1'b1;
            unique case (quote_mode_reg)
                csvrp_pkg::MODE_INSIDE:
                begin
                    if (is_quote)
                    begin
                        quote_mode_next = csvrp_pkg::MODE_PENDING;
                    end
                end
                csvrp_pkg::MODE_PENDING:
                begin
                    if (is_quote)
                    begin
                        quote_mode_next = csvrp_pkg::MODE_INSIDE;
                    end
                    else
                    begin
                        quote_mode_next = csvrp_pkg::MODE_OUTSIDE;
                        if (is_newline)
                        begin
                            record_started_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    if (is_quote)
                    begin
                        quote_mode_next = csvrp_pkg::MODE_INSIDE;
                    end
                    else
                    begin
                        quote_mode_next = csvrp_pkg::MODE_OUTSIDE;
                        if (is_newline)
                        begin
                            record_started_next = 1'b0;
                        end
                    end
                end
            endcase
        end
    end

    // event output
    always_comb
    begin
        has_result      = 1'b0;
        result.out_kind = csvrp_pkg::KIND_CHAR;
        result.out_char = 8'd0;
        if (item.end_of_stream)
        begin
            if (record_started_reg)
            begin
                has_result = 1'b1;
                if (quote_mode_reg == csvrp_pkg::MODE_INSIDE)
                begin
                    result.out_kind = csvrp_pkg::KIND_ERROR;
                end
                else
                begin
                    result.out_kind = csvrp_pkg::KIND_RECORD_END;
                end
            end
        end
        else if (quote_mode_reg == csvrp_pkg::MODE_INSIDE)
        begin
            if (!is_quote)
            begin
                has_result      = 1'b1;
                result.out_char = item.data_byte;
            end
        end
        else if ((quote_mode_reg == csvrp_pkg::MODE_PENDING) && is_quote)
        begin
            has_result      = 1'b1;
            result.out_char = csvrp_pkg::QUOTE_BYTE;
        end
        else if (!is_quote)
        begin
            has_result = 1'b1;
            if (is_newline)
            begin
                result.out_kind = csvrp_pkg::KIND_RECORD_END;
            end
            else if (is_delim)
            begin
                result.out_kind = csvrp_pkg::KIND_FIELD_END;
            end
            else
            begin
                result.out_char = item.data_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg      <= csvrp_pkg::DELIMITER_RESET;
            quote_mode_reg     <= csvrp_pkg::MODE_OUTSIDE;
            record_started_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                delimiter_reg <= cfg_data;
            end
            if (item_valid)
            begin
                quote_mode_reg     <= quote_mode_next;
                record_started_reg <= record_started_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/csvrp_out_skid.sv
// result register with a skid entry toward the master side
`default_nettype none

module csvrp_out_skid
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire csvrp_pkg::result_t push_result,
    output logic                    up_ready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output csvrp_pkg::result_t      m_result
);

    logic               main_valid_reg;
    logic               main_valid_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    csvrp_pkg::result_t main_reg;
    csvrp_pkg::result_t skid_reg;
    logic               main_load;

    assign up_ready  = !skid_valid_reg;
    assign m_tvalid  = main_valid_reg;
    assign m_result  = main_reg;
    assign main_load = m_tready || !main_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (main_load)
        begin
            main_valid_next = skid_valid_reg || push;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_load)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_result;
        end
        else if (push)
        begin
            skid_reg <= push_result;
        end
    end

endmodule

`default_nettype wire
